### hdl/gdr_pkg.sv
package gdr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ROW   = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic {
    KIND_Y     = 1'b0,
    KIND_STATE = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_KEY_LENGTH   = 1'b0,
    CFG_VALUE_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P1,
    ST_E,
    ST_MUL,
    ST_DLT,
    ST_P2,
    ST_Y,
    ST_RD
  } state_e;

  localparam logic [7:0] LenReset = 8'd128;

  typedef struct packed {
    op_e                operation;
    logic [6:0]         key_index;
    logic [6:0]         value_index;
    logic signed [15:0] key_val;
    logic signed [15:0] query_val;
    logic signed [15:0] value_val;
    logic [16:0]        decay;
    logic [16:0]        write_rate;
    logic signed [31:0] state_word;
  } in_item_t;

  typedef struct packed {
    kind_e              result_kind;
    logic [6:0]         out_row;
    logic [6:0]         out_col;
    logic signed [15:0] out_element;
    logic signed [31:0] state_read;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat32_t;

  typedef struct packed {
    logic               sat;
    logic signed [15:0] val;
  } sat16_t;

  function automatic sat32_t sat32(logic signed [63:0] x);
    sat32_t r;
    r.sat = 1'b1;
    if (x > 64'sh7FFF_FFFF) begin
      r.val = 32'sh7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      r.val = -32'sh8000_0000;
    end else begin
      r.val = x[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic sat16_t sat16(logic signed [63:0] x);
    sat16_t r;
    r.sat = 1'b1;
    if (x > 64'sh7FFF) begin
      r.val = 16'sh7FFF;
    end else if (x < -64'sh8000) begin
      r.val = -16'sh8000;
    end else begin
      r.val = x[15:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [16:0] gate_clamp(logic [16:0] raw);
    return (raw > 17'd65536) ? 17'd65536 : raw;
  endfunction

endpackage

### hdl/gdr_stream_if.sv
interface gdr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/gated_delta_rule_step.sv
// One head of the gated delta rule recurrence. After reset the block sweeps the
// recurrent matrix to zero, one word a cycle over all VALUE_DIM*KEY_DIM words, and
// takes no transaction until that is done; config writes are taken at any time.
// Load and write transactions finish in the idle state; a state read passes through
// a read state that waits for a free output slot. A row transaction walks its state
// row twice through the matrix memory (one read and one write a cycle; decay and k
// dot pass, then update and q dot pass), each pass issuing kl words and then draining
// its pipeline, with the E, MUL and DLT states between them for delta; a row outside
// the rows in use is taken with no result. One transaction is in flight at a time; a
// finished result waits in an output register while the next transaction is taken.
module gated_delta_rule_step
  import gdr_pkg::*;
#(
  parameter int KEY_DIM   = 128,
  parameter int VALUE_DIM = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gdr_stream_if.sink           in_i,
  gdr_stream_if.source         out_o,
  input  logic                 cfg_we_i,
  input  cfg_idx_e             cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  localparam int MemDepth = VALUE_DIM * KEY_DIM;
  localparam int AddrW    = $clog2(MemDepth);
  localparam int KIdxW    = $clog2(KEY_DIM);
  localparam int KCntW    = $clog2(KEY_DIM + 1);
  localparam int VCntW    = $clog2(VALUE_DIM + 1);
  localparam int AccW     = 48 + KIdxW;
  localparam int EW       = AccW - 10;
  localparam int PEW      = EW + 18;

  // config registers
  logic [7:0] key_len_q, val_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= LenReset;
      val_len_q <= LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LENGTH:   key_len_q <= cfg_data_i;
        CFG_VALUE_LENGTH: val_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // lengths in use, clipped to the dimensions
  logic [KCntW-1:0] kl;
  logic [VCntW-1:0] vl;
  assign kl = ({1'b0, key_len_q} > 9'(KEY_DIM)) ? KCntW'(KEY_DIM) : KCntW'(key_len_q);
  assign vl = ({1'b0, val_len_q} > 9'(VALUE_DIM)) ? VCntW'(VALUE_DIM) : VCntW'(val_len_q);

  state_e state_q, state_d;

  in_item_t in_d;
  logic     in_fire;
  assign in_d    = in_i.data;
  assign in_fire = in_i.valid && in_i.ready;

  logic col_ok, row_ok, row_use;
  assign col_ok  = {2'b0, in_d.key_index} < 9'(KEY_DIM);
  assign row_ok  = {2'b0, in_d.value_index} < 9'(VALUE_DIM);
  assign row_use = {2'b0, in_d.value_index} < 9'(vl);

  logic [AddrW-1:0] base_in, addr_in;
  assign base_in = AddrW'(32'(in_d.value_index) * KEY_DIM);
  assign addr_in = AddrW'(32'(base_in) + 32'(in_d.key_index));

  // per transaction registers
  logic [6:0]         row_q, col_q;
  logic [16:0]        g_q, beta_q;
  logic signed [15:0] v_q;
  logic [AddrW-1:0]   base_q, rdaddr_q;
  logic               inrange_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q     <= in_d.value_index;
      col_q     <= in_d.key_index;
      g_q       <= gate_clamp(in_d.decay);
      beta_q    <= gate_clamp(in_d.write_rate);
      v_q       <= in_d.value_val;
      base_q    <= base_in;
      rdaddr_q  <= addr_in;
      inrange_q <= row_ok && col_ok;
    end
  end

  // row walk pipeline: issue, memory data, multiply, write back and multiply, accumulate
  logic [KCntW-1:0]   idx_q;
  logic [AddrW-1:0]   clr_q;
  logic               v1_q, v2_q, v3_q;
  logic [AddrW-1:0]   addr1_q, addr2_q;
  logic signed [31:0] rd_s_q, s1_q;
  logic signed [15:0] rd_k_q, rd_q_q, k1_q, q1_q;
  logic signed [49:0] prod1_q;
  logic signed [47:0] prod2_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [EW-1:0]   e_q;
  logic signed [PEW-1:0]  prod_e_q;
  logic signed [31:0]     delta_q;
  logic                   sat_q;

  logic in_pass, issue, pass_done, slot_free;
  assign in_pass   = (state_q == ST_P1) || (state_q == ST_P2);
  assign issue     = in_pass && (idx_q < kl);
  assign pass_done = in_pass && (idx_q == kl) && !v1_q && !v2_q && !v3_q;

  logic out_valid_q;
  out_item_t out_q;
  assign slot_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AddrW'(MemDepth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (in_d.operation == OP_ROW && row_use) begin
            state_d = ST_P1;
          end else if (in_d.operation == OP_READ) begin
            state_d = ST_RD;
          end
        end
      end
      ST_P1:  if (pass_done) state_d = ST_E;
      ST_E:   state_d = ST_MUL;
      ST_MUL: state_d = ST_DLT;
      ST_DLT: state_d = ST_P2;
      ST_P2:  if (pass_done) state_d = ST_Y;
      ST_Y:   if (slot_free) state_d = ST_IDLE;
      ST_RD:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // stage two arithmetic: new state word
  logic signed [63:0] dec_rnd, upd_rnd;
  sat32_t             snew;
  logic signed [47:0] prod2_d;

  always_comb begin
    dec_rnd = 64'((prod1_q + 50'sd32768) >>> 16);
    upd_rnd = 64'(s1_q) + 64'((prod1_q + 50'sd2048) >>> 12);
    snew    = (state_q == ST_P1) ? sat32(dec_rnd) : sat32(upd_rnd);
    prod2_d = snew.val * ((state_q == ST_P1) ? k1_q : q1_q);
  end

  // matrix write port: clearing sweep, state word write, or row write back
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr, rd_addr;
  logic signed [31:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr2_q;
    mem_wdata = snew.val;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (v2_q) begin
      mem_we = 1'b1;
    end else if (in_fire && in_d.operation == OP_WRITE && row_ok && col_ok) begin
      mem_we    = 1'b1;
      mem_waddr = addr_in;
      mem_wdata = in_d.state_word;
    end
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_addr = addr_in;
    end else if (state_q == ST_RD) begin
      rd_addr = rdaddr_q;
    end else begin
      rd_addr = AddrW'(32'(base_q) + 32'(idx_q));
    end
  end

  logic signed [31:0] mat_mem [MemDepth];
  logic signed [15:0] kbuf_mem [KEY_DIM];
  logic signed [15:0] qbuf_mem [KEY_DIM];
  logic               buf_we;
  assign buf_we = in_fire && in_d.operation == OP_LOAD && col_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) mat_mem[mem_waddr] <= mem_wdata;
    rd_s_q <= mat_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      kbuf_mem[KIdxW'(in_d.key_index)] <= in_d.key_val;
      qbuf_mem[KIdxW'(in_d.key_index)] <= in_d.query_val;
    end
    rd_k_q <= kbuf_mem[KIdxW'(idx_q)];
    rd_q_q <= qbuf_mem[KIdxW'(idx_q)];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AddrW'(1);
      if (state_q == ST_IDLE || state_q == ST_DLT) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + KCntW'(1);
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // datapath registers
  logic signed [63:0] e_full;
  sat32_t             dsat;
  assign e_full = ((64'(v_q) <<< 16) - 64'(acc_q) + 64'sd2048) >>> 12;
  assign dsat   = sat32(64'((prod_e_q + PEW'(32768)) >>> 16));

  always_ff @(posedge clk_i) begin
    addr1_q <= rd_addr;
    addr2_q <= addr1_q;
    s1_q    <= rd_s_q;
    k1_q    <= rd_k_q;
    q1_q    <= rd_q_q;
    if (state_q == ST_P1) begin
      prod1_q <= rd_s_q * $signed({1'b0, g_q});
    end else begin
      prod1_q <= 50'(rd_k_q * delta_q);
    end
    prod2_q <= prod2_d;
    if (state_q == ST_IDLE || state_q == ST_E) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + AccW'(prod2_q);
    end
    if (state_q == ST_E) e_q <= EW'(e_full);
    if (state_q == ST_MUL) prod_e_q <= e_q * $signed({1'b0, beta_q});
    if (state_q == ST_DLT) delta_q <= dsat.val;
    if (in_fire) begin
      sat_q <= 1'b0;
    end else if ((v2_q && snew.sat) || (state_q == ST_DLT && dsat.sat)) begin
      sat_q <= 1'b1;
    end
  end

  // output register
  sat16_t    ysat;
  out_item_t res;
  logic      res_load;
  assign ysat     = sat16(64'((acc_q + AccW'(32768)) >>> 16));
  assign res_load = (state_q == ST_Y || state_q == ST_RD) && slot_free;

  always_comb begin
    res.out_row = row_q;
    if (state_q == ST_RD) begin
      res.result_kind = KIND_STATE;
      res.out_col     = col_q;
      res.out_element = '0;
      res.state_read  = inrange_q ? rd_s_q : '0;
      res.saturated   = 1'b0;
    end else begin
      res.result_kind = KIND_Y;
      res.out_col     = '0;
      res.out_element = ysat.val;
      res.state_read  = '0;
      res.saturated   = sat_q || ysat.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // pipeline stages follow one another
  a_v3_from_v2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> $past(v2_q))
    else $error("accumulate stage without a write back stage");

  // a pass hands over only with the pipeline drained
  a_pass_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_P1 && state_d == ST_E) || (state_q == ST_P2 && state_d == ST_Y))
      |-> (!v1_q && !v2_q && !v3_q))
    else $error("pass ended with words in flight");

  // a write back never collides with a state word write
  a_write_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (in_pass && !in_fire))
    else $error("row write back outside a pass");

  // the column counter never runs past the columns in use
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pass |-> (idx_q <= kl))
    else $error("column counter out of range");

  // a result is never dropped while waiting
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("pending result lost");

endmodule

### tb/testbench.sv
module testbench;
  import gdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      DIM        = 128;
  localparam longint  CYCLE_LIMIT = 3_000_000;
  // settle time long enough for the trailing work of any row transaction
  localparam int      SETTLE     = 400;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  cfg_idx_e   cfg_idx_i = CFG_KEY_LENGTH;
  logic [7:0] cfg_data_i = '0;

  gdr_stream_if #(.T(in_item_t))  in_if();
  gdr_stream_if #(.T(out_item_t)) out_if();

  gated_delta_rule_step uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the head: buffers, recurrent matrix, lengths
  logic signed [15:0] key_shadow [DIM];
  logic signed [15:0] query_shadow [DIM];
  bit                 key_loaded [DIM];
  int                 matrix_shadow [DIM][DIM];
  logic [7:0]         key_len_shadow = LenReset;
  logic [7:0]         val_len_shadow = LenReset;

  out_item_t expected_results[$];

  // idle percentages for the sender and the receiver, changed per phase
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;

  int     error_count = 0;
  int     items_sent = 0;
  int     y_checked = 0;
  int     reads_checked = 0;
  int     sat_results = 0;
  longint cycle_count = 0;

  // round half up, then arithmetic shift
  function automatic longint round_shift(longint x, int sh);
    return (x + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic int clamp32(longint x, inout bit hit);
    if (x > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (x < -64'sd2147483648) begin
      hit = 1'b1;
      return -32'sh8000_0000;
    end
    return int'(x);
  endfunction

  function automatic int used_keys();
    return (key_len_shadow > DIM) ? DIM : int'(key_len_shadow);
  endfunction

  function automatic int used_rows();
    return (val_len_shadow > DIM) ? DIM : int'(val_len_shadow);
  endfunction

  // advance the shadow head by one transaction, return 1 if it yields a result
  function automatic bit step_head(in_item_t it, output out_item_t res);
    int     kl;
    int     vl;
    longint g;
    longint beta;
    longint kv;
    longint acc;
    longint e;
    longint y;
    int     dlt;
    bit     hit;
    res = '0;
    hit = 1'b0;
    kl = used_keys();
    vl = used_rows();
    case (it.operation)
      OP_LOAD: begin
        key_shadow[it.key_index] = it.key_val;
        query_shadow[it.key_index] = it.query_val;
        key_loaded[it.key_index] = 1'b1;
        return 1'b0;
      end
      OP_WRITE: begin
        matrix_shadow[it.value_index][it.key_index] = it.state_word;
        return 1'b0;
      end
      OP_READ: begin
        res.result_kind = KIND_STATE;
        res.out_row = it.value_index;
        res.out_col = it.key_index;
        res.state_read = matrix_shadow[it.value_index][it.key_index];
        return 1'b1;
      end
      default: begin
        if (it.value_index >= vl) return 1'b0;
        g = (it.decay > 17'd65536) ? 65536 : longint'(it.decay);
        beta = (it.write_rate > 17'd65536) ? 65536 : longint'(it.write_rate);
        kv = 0;
        acc = 0;
        // decay and k dot pass
        for (int i = 0; i < kl; i++) begin
          matrix_shadow[it.value_index][i] =
            clamp32(round_shift(longint'(matrix_shadow[it.value_index][i]) * g, 16), hit);
          kv += longint'(matrix_shadow[it.value_index][i]) * longint'(key_shadow[i]);
        end
        e = round_shift(longint'(it.value_val) * 65536 - kv, 12);
        dlt = clamp32(round_shift(e * beta, 16), hit);
        // update and q dot pass
        for (int i = 0; i < kl; i++) begin
          matrix_shadow[it.value_index][i] = clamp32(longint'(matrix_shadow[it.value_index][i])
            + round_shift(longint'(key_shadow[i]) * longint'(dlt), 12), hit);
          acc += longint'(matrix_shadow[it.value_index][i]) * longint'(query_shadow[i]);
        end
        y = round_shift(acc, 16);
        if (y > 32767) begin
          y = 32767;
          hit = 1'b1;
        end else if (y < -32768) begin
          y = -32768;
          hit = 1'b1;
        end
        res.result_kind = KIND_Y;
        res.out_row = it.value_index;
        res.out_element = y[15:0];
        res.saturated = hit;
        return 1'b1;
      end
    endcase
  endfunction

  // run length watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // output side: random backpressure and in-order comparison of every result
  always @(posedge clk_i) begin
    out_item_t exp_r;
    out_item_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, got);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.result_kind !== exp_r.result_kind || got.out_row !== exp_r.out_row ||
              got.out_col !== exp_r.out_col || got.out_element !== exp_r.out_element ||
              got.state_read !== exp_r.state_read || got.saturated !== exp_r.saturated) begin
            $display("%0t: mismatch, expected %p actual %p", $time, exp_r, got);
            error_count++;
          end
          if (exp_r.result_kind == KIND_Y) y_checked++;
          else reads_checked++;
          if (exp_r.saturated) sat_results++;
        end
      end
      out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // push one transaction, predicting its result at the accepting edge
  task automatic send_item(in_item_t it);
    out_item_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.data <= it;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    if (step_head(it, res)) expected_results.insert(expected_results.size(), res);
  endtask

  // drop valid and wait for every pending result plus the trailing work of the block
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_config(cfg_idx_e idx, logic [7:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KEY_LENGTH) key_len_shadow = value;
    else val_len_shadow = value;
  endtask

  function automatic in_item_t blank_item(op_e op);
    in_item_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  task automatic load_key(int idx, logic [15:0] k, logic [15:0] q);
    in_item_t it;
    it = blank_item(OP_LOAD);
    it.key_index = idx[6:0];
    it.key_val = k;
    it.query_val = q;
    send_item(it);
  endtask

  task automatic process_row(int row, logic [15:0] v, logic [16:0] g, logic [16:0] b);
    in_item_t it;
    it = blank_item(OP_ROW);
    it.value_index = row[6:0];
    it.value_val = v;
    it.decay = g;
    it.write_rate = b;
    send_item(it);
  endtask

  task automatic state_access(op_e op, int row, int col, logic [31:0] w);
    in_item_t it;
    it = blank_item(op);
    it.value_index = row[6:0];
    it.key_index = col[6:0];
    it.state_word = w;
    send_item(it);
  endtask

  // mostly moderate Q4.12 values, sometimes the full range
  function automatic logic [15:0] rand_q412();
    if ($urandom_range(9) < 2) return 16'($urandom());
    return 16'($urandom_range(8191)) - 16'd4096;
  endfunction

  // gates near one, sometimes anywhere in the 17-bit field
  function automatic logic [16:0] rand_gate();
    case ($urandom_range(9))
      0: return 17'($urandom());
      1: return 17'd65536;
      2: return 17'($urandom_range(65535));
      default: return 17'($urandom_range(65536, 58000));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int sel;
    int kl;
    int vl;
    it = '0;
    it.key_index = 7'($urandom());
    it.value_index = 7'($urandom());
    it.key_val = rand_q412();
    it.query_val = rand_q412();
    it.value_val = rand_q412();
    it.decay = rand_gate();
    it.write_rate = rand_gate();
    it.state_word = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(1 << 20)) - 32'h80000;
    kl = used_keys();
    vl = used_rows();
    sel = $urandom_range(99);
    if (sel < 45) begin
      it.operation = OP_ROW;
      // mostly rows in use, a few outside the range
      if (vl > 0 && $urandom_range(9) != 0) it.value_index = 7'($urandom_range(vl - 1));
      // never let a row read a buffer entry that was never loaded
      for (int i = 0; i < kl; i++) begin
        if (!key_loaded[i]) begin
          it.operation = OP_LOAD;
          it.key_index = i[6:0];
          break;
        end
      end
    end else if (sel < 65) begin
      it.operation = OP_LOAD;
      if (kl > 0 && $urandom_range(3) != 0) it.key_index = 7'($urandom_range(kl - 1));
    end else if (sel < 80) begin
      it.operation = OP_WRITE;
      if (vl > 0 && $urandom_range(3) != 0) it.value_index = 7'($urandom_range(vl - 1));
    end else begin
      it.operation = OP_READ;
      if (vl > 0 && $urandom_range(3) != 0) it.value_index = 7'($urandom_range(vl - 1));
    end
    return it;
  endfunction

  // extremes of the data fields, loads and rows, gate clamp, unused row
  task automatic test_directed_rows();
    write_config(CFG_KEY_LENGTH, 8'd4);
    write_config(CFG_VALUE_LENGTH, 8'd4);
    load_key(0, 16'sh7FFF, 16'sh8000);
    load_key(1, 16'sh8000, 16'sh7FFF);
    load_key(2, 16'h1000, 16'h1000);
    load_key(3, 16'hFFFF, 16'h0001);
    load_key(127, 16'h5555, 16'hAAAA);
    process_row(0, 16'sh7FFF, 17'd65536, 17'd65536);
    process_row(0, 16'sh8000, 17'd65536, 17'd65536);
    process_row(3, 16'h2000, 17'd0, 17'd0);
    process_row(2, 16'h1234, 17'h1FFFF, 17'h1FFFF);
    // row beyond the rows in use: no result
    process_row(4, 16'h1000, 17'd65536, 17'd65536);
    process_row(127, 16'h1000, 17'd65536, 17'd65536);
  endtask

  // cache transfer words, including the extremes and a saturating update
  task automatic test_state_transfer();
    state_access(OP_WRITE, 127, 127, 32'h7FFF_FFFF);
    state_access(OP_READ, 127, 127, '0);
    state_access(OP_READ, 126, 5, '0);
    state_access(OP_WRITE, 1, 0, 32'h8000_0000);
    state_access(OP_WRITE, 1, 1, 32'h7FFF_FFFF);
    process_row(1, 16'sh7FFF, 17'd65536, 17'd65536);
    state_access(OP_READ, 1, 0, '0);
    state_access(OP_READ, 1, 1, '0);
    state_access(OP_WRITE, 1, 0, 32'hFFFF_FFFF);
    state_access(OP_READ, 1, 0, '0);
  endtask

  task automatic test_random_mix(int n, int tx_idle, int rx_idle, bit pause_midway);
    sender_idle_pct = tx_idle;
    receiver_idle_pct = rx_idle;
    for (int i = 0; i < n; i++) begin
      send_item(random_item());
      // hold the sender until the output side has caught up
      if (pause_midway && i == n / 2) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (expected_results.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    for (int i = 0; i < DIM; i++) begin
      key_loaded[i] = 1'b0;
      key_shadow[i] = '0;
      query_shadow[i] = '0;
      for (int j = 0; j < DIM; j++) matrix_shadow[i][j] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_rows();
    test_state_transfer();

    // small head, sender rarely idle, receiver mostly stalled
    write_config(CFG_KEY_LENGTH, 8'd16);
    write_config(CFG_VALUE_LENGTH, 8'd8);
    test_random_mix(150, 11, 72, 1'b1);

    // full width head, roles swapped
    write_config(CFG_KEY_LENGTH, 8'd128);
    write_config(CFG_VALUE_LENGTH, 8'd128);
    test_random_mix(130, 72, 11, 1'b0);

    // lengths past the dimension, single key, then nothing in use; no idling
    write_config(CFG_KEY_LENGTH, 8'd1);
    write_config(CFG_VALUE_LENGTH, 8'd255);
    test_random_mix(100, 0, 0, 1'b0);
    write_config(CFG_KEY_LENGTH, 8'd0);
    write_config(CFG_VALUE_LENGTH, 8'd3);
    test_random_mix(40, 0, 0, 1'b0);
    write_config(CFG_KEY_LENGTH, 8'd255);
    write_config(CFG_VALUE_LENGTH, 8'd0);
    test_random_mix(40, 0, 0, 1'b0);
    write_config(CFG_VALUE_LENGTH, 8'd32);
    test_random_mix(60, 0, 0, 1'b0);

    drain();
    $display("covered %0d transactions: %0d outputs y and %0d state reads checked",
             items_sent, y_checked, reads_checked);
    $display("%0d results saturated, key lengths 0 to 255 and row counts 0 to 255",
             sat_results);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
hdl/gdr_pkg.sv
hdl/gdr_stream_if.sv
hdl/gated_delta_rule_step.sv
tb/testbench.sv
